/* sv/ham6_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the HAM6 pixel encoder.
// No dependencies.
package ham6_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned PAL_DIST_W = 16;
   localparam int unsigned HAM_DIST_W = 17;

   // channel phase: which channel a pixel may modify
   localparam logic [1:0] PHASE_BLUE    = 2'd0;
   localparam logic [1:0] PHASE_GREEN_A = 2'd1;
   localparam logic [1:0] PHASE_RED     = 2'd2;
   localparam logic [1:0] PHASE_GREEN_B = 2'd3;

   // control field of a HAM code byte
   localparam logic [1:0] CTRL_PALETTE = 2'b00;
   localparam logic [1:0] CTRL_BLUE    = 2'b01;
   localparam logic [1:0] CTRL_RED     = 2'b10;
   localparam logic [1:0] CTRL_GREEN   = 2'b11;

   // classified pixel handed from the front end to the encoder back end
   typedef struct packed {
      logic [23:0]           pixel_rgb;
      logic                  row_start;
      logic [PAL_DIST_W-1:0] pal_dist;
   } ham6_item_type;

endpackage

/* sv/ham6_if.sv */
`timescale 1ns / 1ps
// Stream interfaces for the HAM6 pixel encoder: pixel requests and code responses.
// No dependencies.
interface ham6_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_rgb;
   logic        row_start;

   modport source (output valid, output pixel_rgb, output row_start, input ready);
   modport sink   (input valid, input pixel_rgb, input row_start, output ready);
endinterface

interface ham6_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ham_code;

   modport source (output valid, output ham_code, input ready);
   modport sink   (input valid, input ham_code, output ready);
endinterface

/* sv/ham6_front.sv */
`timescale 1ns / 1ps
// Front end: takes pixel transfers and registers them with their palette distance.
// Depends on ham6_pkg and ham6_req_if.
module ham6_front
   import ham6_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ham6_req_if.sink      req_if,
   output logic          item_valid,
   input  logic          item_ready,
   output ham6_item_type item
);

   logic          valid_ff, valid_in;
   ham6_item_type item_ff, item_in;
   logic          take;

   logic [6:0]  r_lo, b_lo;
   logic [5:0]  g_lo;
   logic [13:0] r_sq, b_sq;
   logic [11:0] g_sq;

   assign req_if.ready = !reset && (!valid_ff || item_ready);
   assign take         = req_if.valid && req_if.ready;

   assign r_lo = req_if.pixel_rgb[22:16];
   assign g_lo = req_if.pixel_rgb[13:8];
   assign b_lo = req_if.pixel_rgb[6:0];

   always_comb begin
      r_sq = r_lo * r_lo;
      g_sq = g_lo * g_lo;
      b_sq = b_lo * b_lo;
      item_in.pixel_rgb = req_if.pixel_rgb;
      item_in.row_start = req_if.row_start;
      // max sum is 36227, fits in 16 bits
      item_in.pal_dist  = PAL_DIST_W'(r_sq) + PAL_DIST_W'(g_sq) + PAL_DIST_W'(b_sq);
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/ham6_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified pixels between the front end and the back end.
// Depends on ham6_pkg.
module ham6_queue
   import ham6_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   output logic          wr_ready,
   input  ham6_item_type wr_item,
   output logic          rd_valid,
   input  logic          rd_ready,
   output ham6_item_type rd_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ham6_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* sv/ham6_back.sv */
`timescale 1ns / 1ps
// Back end: holds the previous colour and phase, picks palette or modify code.
// Depends on ham6_pkg and ham6_rsp_if.
module ham6_back
   import ham6_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ham6_item_type in_item,
   ham6_rsp_if.source    rsp_if
);

   logic [7:0] prev_red_ff, prev_red_in;
   logic [7:0] prev_green_ff, prev_green_in;
   logic [7:0] prev_blue_ff, prev_blue_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] code_ff, code_in;

   logic       take;
   logic [7:0] r, g, b;
   logic [7:0] pr, pg, pb;
   logic [1:0] phase;
   logic [7:0] dr, dg, db;
   logic [7:0] op_a, op_b;
   logic [15:0] sq_a, sq_b;
   logic [HAM_DIST_W-1:0] ham_dist;
   logic       use_palette;

   assign in_ready = !rsp_valid_ff || rsp_if.ready;
   assign take     = in_valid && in_ready;

   assign r = in_item.pixel_rgb[23:16];
   assign g = in_item.pixel_rgb[15:8];
   assign b = in_item.pixel_rgb[7:0];

   // row start clears phase and history ahead of this pixel
   assign pr    = in_item.row_start ? 8'd0 : prev_red_ff;
   assign pg    = in_item.row_start ? 8'd0 : prev_green_ff;
   assign pb    = in_item.row_start ? 8'd0 : prev_blue_ff;
   assign phase = in_item.row_start ? PHASE_BLUE : phase_ff;

   assign dr = (r >= pr) ? r - pr : pr - r;
   assign dg = (g >= pg) ? g - pg : pg - g;
   assign db = (b >= pb) ? b - pb : pb - b;

   // the two channels this phase leaves alone
   assign op_a = (phase == PHASE_RED)  ? dg : dr;
   assign op_b = (phase == PHASE_BLUE) ? dg : db;

   always_comb begin
      sq_a        = op_a * op_a;
      sq_b        = op_b * op_b;
      ham_dist    = HAM_DIST_W'(sq_a) + HAM_DIST_W'(sq_b);
      use_palette = HAM_DIST_W'(in_item.pal_dist) < ham_dist;
   end

   always_comb begin
      prev_red_in   = prev_red_ff;
      prev_green_in = prev_green_ff;
      prev_blue_in  = prev_blue_ff;
      phase_in      = phase_ff;
      code_in       = code_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in  = 1'b1;
         phase_in      = phase + 2'd1;
         prev_red_in   = pr;
         prev_green_in = pg;
         prev_blue_in  = pb;
         if (use_palette) begin
            code_in       = {CTRL_PALETTE, r[7], g[7:6], b[7], 2'b00};
            prev_red_in   = {r[7:6], 6'd0};
            prev_green_in = {g[7:6], 6'd0};
            prev_blue_in  = {b[7:6], 6'd0};
         end else begin
            case (phase)
               PHASE_BLUE: begin
                  code_in      = {CTRL_BLUE, b[7:2]};
                  prev_blue_in = b;
               end
               PHASE_RED: begin
                  code_in     = {CTRL_RED, r[7:2]};
                  prev_red_in = r;
               end
               default: begin
                  code_in       = {CTRL_GREEN, g[7:2]};
                  prev_green_in = g;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_red_ff   <= 8'd0;
         prev_green_ff <= 8'd0;
         prev_blue_ff  <= 8'd0;
         phase_ff      <= PHASE_BLUE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_red_ff   <= prev_red_in;
         prev_green_ff <= prev_green_in;
         prev_blue_ff  <= prev_blue_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.ham_code = code_ff;

endmodule

/* sv/ham6_pixel_encoder.sv */
`timescale 1ns / 1ps
// HAM6 pixel encoder: one RGB pixel in, one HAM code byte out.
// A code is valid after its pixel passes the front register (loaded at the transfer edge),
// a queue slot and the output register. Throughput: one pixel per cycle while the code
// receiver is ready. Synchronous active-high reset clears the history, phase, queue and
// all valid flags; ready stays low while reset is high.
// Depends on ham6_pkg, ham6_if, ham6_front, ham6_queue, ham6_back.
module ham6_pixel_encoder
   import ham6_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ham6_req_if.sink   req_if,
   ham6_rsp_if.source rsp_if
);

   logic          fr_valid, fr_ready;
   ham6_item_type fr_item;
   logic          bk_valid, bk_ready;
   ham6_item_type bk_item;

   ham6_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (fr_valid),
      .item_ready (fr_ready),
      .item       (fr_item)
   );

   ham6_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_item  (fr_item),
      .rd_valid (bk_valid),
      .rd_ready (bk_ready),
      .rd_item  (bk_item)
   );

   ham6_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bk_valid),
      .in_ready (bk_ready),
      .in_item  (bk_item),
      .rsp_if   (rsp_if)
   );

endmodule

/* sv/ham6_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the HAM6 pixel encoder, bound to the top level.
// Depends on ham6_pkg and ham6_pixel_encoder.
module ham6_checker
   import ham6_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] ham_code
);

   // front register + queue + output register
   localparam int unsigned MAX_OUT = 4;

   logic [2:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ham_code))
      else $error("response changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0 && pending_ff <= 3'(MAX_OUT))
      else $error("response without outstanding pixel, or too many in flight");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer && pending_ff == 3'd0 |=> !rsp_valid)
      else $error("code appeared faster than the pipeline allows");

   a_palette_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ham_code[7:6] == CTRL_PALETTE |-> ham_code[1:0] == 2'b00)
      else $error("palette code with nonzero low bits");

endmodule

bind ham6_pixel_encoder ham6_checker u_ham6_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .ham_code  (rsp_if.ham_code)
);

/* verif/ham6_checker.sv */
`timescale 1ns / 1ps
// Checker for the HAM6 pixel encoder: watches the pixel and code channels,
// predicts each code byte and compares it on transfer. Depends on ham6_pkg, ham6_if.
module ham6_scoreboard
   import ham6_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ham6_req_if  req_mon,
   ham6_rsp_if  rsp_mon,
   output int   outstanding,
   output int   fail_count
);

   logic [7:0] hist_red;
   logic [7:0] hist_green;
   logic [7:0] hist_blue;
   logic [1:0] hist_phase;
   logic [7:0] code_queue[$];

   function automatic int unsigned sq_diff(input logic [7:0] a, input logic [7:0] b);
      int unsigned d;
      d = (a >= b) ? int'(a - b) : int'(b - a);
      return d * d;
   endfunction

   // Advances the colour history by one pixel and returns its code byte.
   function automatic logic [7:0] encode_pixel(input logic [23:0] rgb, input logic row_start);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      int unsigned pal_dist;
      int unsigned ham_dist;
      logic [7:0]  code;
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      if (row_start) begin
         hist_red   = '0;
         hist_green = '0;
         hist_blue  = '0;
         hist_phase = PHASE_BLUE;
      end
      pal_dist = r[6:0] * r[6:0] + g[5:0] * g[5:0] + b[6:0] * b[6:0];
      case (hist_phase)
         PHASE_BLUE: ham_dist = sq_diff(r, hist_red) + sq_diff(g, hist_green);
         PHASE_RED:  ham_dist = sq_diff(g, hist_green) + sq_diff(b, hist_blue);
         default:    ham_dist = sq_diff(r, hist_red) + sq_diff(b, hist_blue);
      endcase
      // ties go to the modify code
      if (pal_dist < ham_dist) begin
         code       = {CTRL_PALETTE, r[7], g[7:6], b[7], 2'b00};
         hist_red   = r & 8'hc0;
         hist_green = g & 8'hc0;
         hist_blue  = b & 8'hc0;
      end else begin
         case (hist_phase)
            PHASE_BLUE: begin
               code      = {CTRL_BLUE, b[7:2]};
               hist_blue = b;
            end
            PHASE_RED: begin
               code     = {CTRL_RED, r[7:2]};
               hist_red = r;
            end
            default: begin
               code       = {CTRL_GREEN, g[7:2]};
               hist_green = g;
            end
         endcase
      end
      hist_phase = hist_phase + 2'd1;
      return code;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
      hist_red    = '0;
      hist_green  = '0;
      hist_blue   = '0;
      hist_phase  = PHASE_BLUE;
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         code_queue.delete();
         hist_red   = '0;
         hist_green = '0;
         hist_blue  = '0;
         hist_phase = PHASE_BLUE;
      end else begin
         if (req_mon.valid && req_mon.ready)
            code_queue.push_back(encode_pixel(req_mon.pixel_rgb, req_mon.row_start));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (code_queue.size() == 0) begin
               $error("ham_code: no code expected, actual %02h", rsp_mon.ham_code);
               fail_count = fail_count + 1;
            end else begin
               want = code_queue.pop_front();
               if (rsp_mon.ham_code !== want) begin
                  $error("ham_code: expected %02h, actual %02h", want, rsp_mon.ham_code);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      outstanding = code_queue.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// HAM6 pixel encoder testbench top: clock, reset, pixel stimulus, code receiver with
// random stalls. Depends on ham6_pkg, ham6_if, ham6_pixel_encoder, ham6_scoreboard.
module testbench;
   import ham6_pkg::*;

   localparam int RANDOM_PIXELS = 700;
   localparam int LONG_HOLD     = 300;

   logic clock;
   logic reset;
   int   outstanding;
   int   fail_count;
   int   rsp_hold_cycles;
   bit   burst_mode;
   int   pixels_sent;

   ham6_req_if req_chan();
   ham6_rsp_if rsp_chan();

   ham6_pixel_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   ham6_scoreboard checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_pixel(input logic [23:0] rgb, input logic row_start);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.pixel_rgb <= rgb;
      req_chan.row_start <= row_start;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      pixels_sent = pixels_sent + 1;
   endtask

   // code receiver
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [23:0] rgb;
      logic [23:0] last_rgb;
      logic        row_start;
      int          row_len;
      int          style;
      bit          hold_done;
      bit          pause_done;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.pixel_rgb = '0;
      req_chan.row_start = 1'b0;
      rsp_hold_cycles    = 0;
      burst_mode         = 1'b0;
      pixels_sent        = 0;
      hold_done          = 1'b0;
      pause_done         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, each phase with palette and modify, ties, wrap
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'hffffff, 1'b0);
      send_pixel(24'hffffff, 1'b0);
      send_pixel(24'hff0000, 1'b0);
      send_pixel(24'h00ff00, 1'b0);
      send_pixel(24'h0000ff, 1'b0);
      send_pixel(24'h808080, 1'b1);   // palette: masked distance is zero
      send_pixel(24'hc0c0c0, 1'b0);
      send_pixel(24'h80c080, 1'b0);
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'h102000, 1'b1);   // equal distances, modify wins
      send_pixel(24'h100000, 1'b0);
      send_pixel(24'h000010, 1'b0);
      send_pixel(24'h3f3f3f, 1'b0);
      send_pixel(24'h7f3f7f, 1'b0);
      send_pixel(24'hfe01fe, 1'b0);
      send_pixel(24'h01fe01, 1'b0);
      send_pixel(24'hff00ff, 1'b1);
      send_pixel(24'h00ff00, 1'b0);
      send_pixel(24'hffffff, 1'b1);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'h7f7f7f, 1'b0);

      last_rgb = 24'h000000;
      while (pixels_sent < RANDOM_PIXELS + 22) begin
         row_len    = $urandom_range(1, 24);
         style      = $urandom_range(0, 9);
         burst_mode = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < row_len; k++) begin
            row_start = (k == 0) || ($urandom_range(0, 19) == 0);
            case (style)
               0, 1, 2, 3: rgb = 24'($urandom & 24'hffffff);
               4, 5, 6:    rgb = last_rgb ^ 24'($urandom & 24'h1f1f1f);
               7, 8:       rgb = 24'(($urandom & 24'hc0c0c0) | ($urandom & 24'h0f070f));
               default:    rgb = {{8{$urandom_range(0, 1) == 1}},
                                  {8{$urandom_range(0, 1) == 1}},
                                  {8{$urandom_range(0, 1) == 1}}};
            endcase
            last_rgb = rgb;
            send_pixel(rgb, row_start);
         end
         // receiver holds off while pixels keep coming, so the input backs up
         if (!hold_done && pixels_sent > 250) begin
            hold_done       = 1'b1;
            burst_mode      = 1'b1;
            rsp_hold_cycles = LONG_HOLD;
            for (int k = 0; k < 12; k++)
               send_pixel(24'($urandom & 24'hffffff), k == 0);
            burst_mode = 1'b0;
         end
         // drain completely before going on
         if (!pause_done && pixels_sent > 500) begin
            pause_done     = 1'b1;
            req_chan.valid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      burst_mode = 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* ham6_pixel_encoder.f */
sv/ham6_pkg.sv
sv/ham6_if.sv
sv/ham6_front.sv
sv/ham6_queue.sv
sv/ham6_back.sv
sv/ham6_pixel_encoder.sv
sv/ham6_checker.sv
verif/ham6_checker.sv
verif/testbench.sv
